[hw/rtl/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 byte decoder.
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned CntW  = 2;

  // Replacement character sent for an invalid lead byte
  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // Continuation bytes still expected after each kind of lead
  localparam logic [CntW-1:0] NeedNone  = 2'd0;
  localparam logic [CntW-1:0] NeedOne   = 2'd1;
  localparam logic [CntW-1:0] NeedTwo   = 2'd2;
  localparam logic [CntW-1:0] NeedThree = 2'd3;

  // Sequence assembly state
  typedef struct packed {
    logic [CpW-1:0]  partial_value;
    logic [CntW-1:0] bytes_needed;
  } dec_state_t;

  // One decode result
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic           invalid;
  } dec_result_t;

endpackage

[hw/rtl/utf8d_decode.sv]
// Single-step UTF-8 decode: current state plus one byte gives next state and result.
module utf8d_decode (
  input  logic [utf8d_pkg::ByteW-1:0] byte_in,
  input  utf8d_pkg::dec_state_t       state,
  output utf8d_pkg::dec_state_t       state_next,
  output utf8d_pkg::dec_result_t      result
);

  logic                        is_cont;
  logic [utf8d_pkg::CpW-1:0]   shifted;
  logic [utf8d_pkg::CntW-1:0]  cnt_dec;
  utf8d_pkg::dec_state_t       lead_state;
  utf8d_pkg::dec_result_t      lead_result;

  assign is_cont = (byte_in[7:6] == 2'b10);
  assign shifted = {state.partial_value[utf8d_pkg::CpW-7:0], byte_in[5:0]};
  assign cnt_dec = state.bytes_needed - utf8d_pkg::NeedOne;

  // Lead byte decode from an empty state
  always_comb begin
    lead_state.partial_value = '0;
    lead_state.bytes_needed  = utf8d_pkg::NeedNone;
    lead_result.valid        = 1'b0;
    lead_result.code_point   = '0;
    lead_result.invalid      = 1'b0;
    if (byte_in[7] == 1'b0) begin
      lead_result.valid      = 1'b1;
      lead_result.code_point = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, byte_in};
    end else if (byte_in[7:5] == 3'b110) begin
      lead_state.partial_value = {{(utf8d_pkg::CpW-5){1'b0}}, byte_in[4:0]};
      lead_state.bytes_needed  = utf8d_pkg::NeedOne;
    end else if (byte_in[7:4] == 4'b1110) begin
      lead_state.partial_value = {{(utf8d_pkg::CpW-4){1'b0}}, byte_in[3:0]};
      lead_state.bytes_needed  = utf8d_pkg::NeedTwo;
    end else if (byte_in[7:3] == 5'b11110) begin
      lead_state.partial_value = {{(utf8d_pkg::CpW-3){1'b0}}, byte_in[2:0]};
      lead_state.bytes_needed  = utf8d_pkg::NeedThree;
    end else begin
      lead_result.valid      = 1'b1;
      lead_result.code_point = utf8d_pkg::Replacement;
      lead_result.invalid    = 1'b1;
    end
  end

  // Continue an open sequence, or restart on a broken one
  always_comb begin
    state_next = lead_state;
    result     = lead_result;
    if (state.bytes_needed != utf8d_pkg::NeedNone && is_cont) begin
      result.invalid = 1'b0;
      if (cnt_dec == utf8d_pkg::NeedNone) begin
        state_next.partial_value = '0;
        state_next.bytes_needed  = utf8d_pkg::NeedNone;
        result.valid             = 1'b1;
        result.code_point        = shifted;
      end else begin
        state_next.partial_value = shifted;
        state_next.bytes_needed  = cnt_dec;
        result.valid             = 1'b0;
        result.code_point        = '0;
      end
    end
  end

endmodule

[hw/rtl/utf8_byte_decoder_core.sv]
// Top level of the UTF-8 byte decoder: input register, decode step, result register.
// A byte passes the input register, then the result register, before its code point is offered.
// Throughput: one byte per cycle while no result waits under out_stall; utf8d_decode is combinational.
// Input and result registers decouple the channels, so one byte can be held in the input register while a result waits.
// Reset (synchronous, rst high) empties both registers and clears the partial value and count.
module utf8_byte_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [utf8d_pkg::ByteW-1:0] byte_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [utf8d_pkg::CpW-1:0]   code_point,
  output logic                        invalid
);

  logic                        req_valid;
  logic [utf8d_pkg::ByteW-1:0] req_byte;
  logic                        step;
  utf8d_pkg::dec_state_t       state;
  utf8d_pkg::dec_state_t       state_next;
  utf8d_pkg::dec_result_t      dec_res;

  // Decode the held request when the result register can take its outcome
  assign step     = req_valid && !(out_valid && out_stall);
  assign in_stall = req_valid && !step;

  utf8d_decode u_decode (
    .byte_in    (req_byte),
    .state      (state),
    .state_next (state_next),
    .result     (dec_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_byte <= byte_req;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.partial_value <= '0;
      state.bytes_needed  <= utf8d_pkg::NeedNone;
    end else if (step) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= dec_res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && dec_res.valid) begin
      code_point <= dec_res.code_point;
      invalid    <= dec_res.invalid;
    end
  end

endmodule
